// ----- src/websocket_frame_deframer_assert.svh -----
// Assertion macros shared by the deframer modules.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wsd_pkg.sv -----
// Types, constants and helpers for the websocket frame deframer.
package wsd_pkg;

    localparam int LENGTH_WIDTH = 64;
    localparam int CMP_W = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;
    localparam int CFG_W = 32;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;

    localparam logic [2:0] HCNT_LEN16_LAST = 3'd1;
    localparam logic [2:0] HCNT_LEN64_LAST = 3'd7;
    localparam logic [2:0] HCNT_MASK_LAST  = 3'd3;

    localparam logic CFG_DEFLATE  = 1'b0;
    localparam logic CFG_MAX_BODY = 1'b1;

    localparam logic [CFG_W-1:0] MAX_BODY_RESET = 32'd1048576;

    typedef enum logic [2:0] {
        ST_FIRST   = 3'd0,
        ST_SECOND  = 3'd1,
        ST_LEN16   = 3'd2,
        ST_LEN64   = 3'd3,
        ST_MASK    = 3'd4,
        ST_PAYLOAD = 3'd5
    } t_stage;

    typedef enum logic [2:0] {
        STS_HDR_BYTE  = 3'd0,
        STS_HDR_DONE  = 3'd1,
        STS_PAYLOAD   = 3'd2,
        STS_BAD_FRAME = 3'd3,
        STS_TOO_LARGE = 3'd4
    } t_status;

    typedef struct packed {
        logic             deflate_en;
        logic [CFG_W-1:0] max_body;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] payload_byte;
        logic [3:0] opcode;
        logic       control;
        logic       text;
        logic       compressed;
        logic       frame_last;
        logic       message_last;
    } t_result;

    function automatic logic is_ctrl(input logic [3:0] op);
        is_ctrl = (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

// ----- src/wsd_parser.sv -----
// Frame parser: header decode, rule checks, unmasking and message tracking.
`include "websocket_frame_deframer_assert.svh"

module wsd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  wsd_pkg::t_cfg   i_cfg,
    output wsd_pkg::t_result o_result
);
    import wsd_pkg::*;

    t_stage                  r_stage,     n_stage;
    logic [2:0]              r_hcnt,      n_hcnt;
    logic                    r_fin,       n_fin;
    logic [3:0]              r_opcode,    n_opcode;
    logic [31:0]             r_mask,      n_mask;
    logic [LENGTH_WIDTH-1:0] r_frame_len, n_frame_len;
    logic                    r_len_ovf,   n_len_ovf;
    logic [LENGTH_WIDTH-1:0] r_pay_cnt,   n_pay_cnt;
    logic                    r_frag,      n_frag;
    logic                    r_text,      n_text;
    logic                    r_comp,      n_comp;
    logic                    r_msg_open,  n_msg_open;

    t_result res;

    always_comb begin
        logic                    fail;
        t_status                 fail_sts;
        logic                    end_frame;
        logic                    flast;
        t_status                 sts;
        logic [7:0]              pbyte;
        logic [3:0]              em_op;
        logic                    em_fin;
        logic                    em_text;
        logic                    em_comp;
        logic                    ovf_new;
        logic [2:0]              last_idx;
        logic [LENGTH_WIDTH-1:0] cnt_inc;
        logic                    fb_fin;
        logic                    fb_r1;
        logic [3:0]              fb_op;
        logic                    bad;

        n_stage     = r_stage;
        n_hcnt      = r_hcnt;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_mask      = r_mask;
        n_frame_len = r_frame_len;
        n_len_ovf   = r_len_ovf;
        n_pay_cnt   = r_pay_cnt;
        n_frag      = r_frag;
        n_text      = r_text;
        n_comp      = r_comp;
        n_msg_open  = r_msg_open;

        fail      = 1'b0;
        fail_sts  = STS_BAD_FRAME;
        end_frame = 1'b0;
        flast     = 1'b0;
        sts       = STS_HDR_BYTE;
        pbyte     = 8'd0;
        ovf_new   = 1'b0;
        last_idx  = HCNT_LEN16_LAST;
        cnt_inc   = r_pay_cnt + LENGTH_WIDTH'(1);
        fb_fin    = i_byte[7];
        fb_r1     = i_byte[6];
        fb_op     = i_byte[3:0];
        bad       = 1'b0;

        case (r_stage)
            ST_SECOND: begin
                if (!i_byte[7]) begin
                    fail = 1'b1;
                end else if (is_ctrl(r_opcode) && (i_byte[6:0] > LEN7_CTRL_MAX)) begin
                    fail = 1'b1;
                end else begin
                    n_hcnt    = 3'd0;
                    n_len_ovf = 1'b0;
                    if (i_byte[6:0] == LEN7_EXT16) begin
                        n_frame_len = '0;
                        n_stage     = ST_LEN16;
                    end else if (i_byte[6:0] == LEN7_EXT64) begin
                        n_frame_len = '0;
                        n_stage     = ST_LEN64;
                    end else begin
                        n_frame_len = LENGTH_WIDTH'(i_byte[6:0]);
                        n_stage     = ST_MASK;
                    end
                end
            end
            ST_LEN16, ST_LEN64: begin
                // bits pushed past the length width make the frame too large
                ovf_new     = r_len_ovf | (|r_frame_len[LENGTH_WIDTH-1:LENGTH_WIDTH-8]);
                n_frame_len = {r_frame_len[LENGTH_WIDTH-9:0], i_byte};
                last_idx    = (r_stage == ST_LEN16) ? HCNT_LEN16_LAST : HCNT_LEN64_LAST;
                if (r_hcnt == last_idx) begin
                    n_hcnt = 3'd0;
                    if (ovf_new) begin
                        fail     = 1'b1;
                        fail_sts = STS_TOO_LARGE;
                    end else begin
                        n_stage = ST_MASK;
                    end
                end else begin
                    n_hcnt    = r_hcnt + 3'd1;
                    n_len_ovf = ovf_new;
                end
            end
            ST_MASK: begin
                n_mask = {r_mask[23:0], i_byte};
                if (r_hcnt == HCNT_MASK_LAST) begin
                    n_hcnt    = 3'd0;
                    n_pay_cnt = '0;
                    n_stage   = ST_PAYLOAD;
                    sts       = STS_HDR_DONE;
                    if (r_frame_len == '0) begin
                        flast     = 1'b1;
                        end_frame = 1'b1;
                    end
                end else begin
                    n_hcnt = r_hcnt + 3'd1;
                end
            end
            ST_PAYLOAD: begin
                if (!is_ctrl(r_opcode) &&
                    (CMP_W'(r_pay_cnt) >= CMP_W'(i_cfg.max_body))) begin
                    fail     = 1'b1;
                    fail_sts = STS_TOO_LARGE;
                end else begin
                    case (r_pay_cnt[1:0])
                        2'd0:    pbyte = i_byte ^ r_mask[31:24];
                        2'd1:    pbyte = i_byte ^ r_mask[23:16];
                        2'd2:    pbyte = i_byte ^ r_mask[15:8];
                        default: pbyte = i_byte ^ r_mask[7:0];
                    endcase
                    n_pay_cnt = cnt_inc;
                    sts       = STS_PAYLOAD;
                    flast     = (cnt_inc == r_frame_len);
                    end_frame = flast;
                end
            end
            default: begin
                // first header byte; unused stage codes land here too
                bad = !((fb_op == OP_CONT) || (fb_op == OP_TEXT) || (fb_op == OP_BIN) ||
                        is_ctrl(fb_op)) || (i_byte[5:4] != 2'b00);
                if (!bad) begin
                    if (is_ctrl(fb_op)) begin
                        bad = !fb_fin || fb_r1;
                    end else begin
                        if (fb_op == OP_CONT) begin
                            bad = !r_frag || fb_r1;
                        end else begin
                            bad = r_frag;
                        end
                        if (fb_r1 && !i_cfg.deflate_en) begin
                            bad = 1'b1;
                        end
                    end
                end
                if (bad) begin
                    fail = 1'b1;
                end else begin
                    n_fin    = fb_fin;
                    n_opcode = fb_op;
                    if (!is_ctrl(fb_op)) begin
                        if (fb_op != OP_CONT) begin
                            n_msg_open = 1'b1;
                            n_text     = (fb_op == OP_TEXT);
                            n_comp     = fb_r1;
                        end
                        n_frag = !fb_fin;
                    end
                    n_stage = ST_SECOND;
                end
            end
        endcase

        // first byte reports the frame it just opened
        if (r_stage == ST_FIRST || r_stage > ST_PAYLOAD) begin
            em_op   = n_opcode;
            em_fin  = n_fin;
            em_text = n_text;
            em_comp = n_comp;
        end else begin
            em_op   = r_opcode;
            em_fin  = r_fin;
            em_text = r_text;
            em_comp = r_comp;
        end

        res.status       = sts;
        res.payload_byte = pbyte;
        res.opcode       = em_op;
        res.control      = is_ctrl(em_op);
        res.text         = em_text;
        res.compressed   = em_comp;
        res.frame_last   = flast;
        res.message_last = flast & em_fin;

        if (end_frame) begin
            if (!is_ctrl(r_opcode) && r_fin) begin
                n_msg_open = 1'b0;
                n_text     = 1'b0;
                n_comp     = 1'b0;
                n_frag     = 1'b0;
            end
            n_stage     = ST_FIRST;
            n_hcnt      = 3'd0;
            n_fin       = 1'b0;
            n_opcode    = OP_CONT;
            n_mask      = '0;
            n_frame_len = '0;
            n_len_ovf   = 1'b0;
            n_pay_cnt   = '0;
        end

        if (fail) begin
            n_stage     = ST_FIRST;
            n_hcnt      = 3'd0;
            n_fin       = 1'b0;
            n_opcode    = OP_CONT;
            n_mask      = '0;
            n_frame_len = '0;
            n_len_ovf   = 1'b0;
            n_pay_cnt   = '0;
            n_frag      = 1'b0;
            n_text      = 1'b0;
            n_comp      = 1'b0;
            n_msg_open  = 1'b0;
            res         = '0;
            res.status  = fail_sts;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_FIRST;
            r_hcnt      <= 3'd0;
            r_fin       <= 1'b0;
            r_opcode    <= OP_CONT;
            r_mask      <= '0;
            r_frame_len <= '0;
            r_len_ovf   <= 1'b0;
            r_pay_cnt   <= '0;
            r_frag      <= 1'b0;
            r_text      <= 1'b0;
            r_comp      <= 1'b0;
            r_msg_open  <= 1'b0;
        end else if (i_accept) begin
            r_stage     <= n_stage;
            r_hcnt      <= n_hcnt;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_mask      <= n_mask;
            r_frame_len <= n_frame_len;
            r_len_ovf   <= n_len_ovf;
            r_pay_cnt   <= n_pay_cnt;
            r_frag      <= n_frag;
            r_text      <= n_text;
            r_comp      <= n_comp;
            r_msg_open  <= n_msg_open;
        end
    end

    `WSD_ASSERT_NOW(a_payload_count_in_range, r_stage == ST_PAYLOAD, r_pay_cnt < r_frame_len,
        "payload count reached frame length without ending the frame")
    `WSD_ASSERT_NOW(a_frag_needs_message, r_frag, r_msg_open,
        "fragmented message flag without an open message")
    `WSD_ASSERT_NEXT(a_error_clears_state,
        i_accept && ((res.status == STS_BAD_FRAME) || (res.status == STS_TOO_LARGE)),
        (r_stage == ST_FIRST) && !r_msg_open && !r_frag,
        "error result did not clear parser state")

endmodule

// ----- src/websocket_frame_deframer.sv -----
// Top level of the websocket frame deframer: config registers, parser, result queue.
//
// Client-to-server websocket deframer. One stream byte is taken per request on
// the input channel and exactly one result comes back per byte, in order: a
// status code (header byte, header complete, payload byte, bad frame, too
// large), the unmasked payload byte, and the frame/message tags. Throughput is
// one byte per clock unless the queue is full: the parser decodes the header
// stages, checks the framing rules and unmasks the payload in a single pass
// between its state registers and a two-entry result queue; each result is
// registered into the queue and offered once those ahead of it are taken. The
// input stalls only while both queue entries hold results the consumer has not
// taken, so a single stalled result never stops the input. Any error result
// (bad frame or too large) carries zeros in every field but status and returns
// the parser to the first header byte with no message open; the config
// registers are kept. Config writes (index 0: deflate enable, index 1: body
// limit in bytes) are meant for idle periods only, with no results still queued.
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write port
    input  logic                     i_cfg_wr_en,
    input  logic                     i_cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0] i_cfg_data,
    // byte input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_data_byte,
    // result output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic [7:0]               o_payload_byte,
    output logic [3:0]               o_frame_opcode,
    output logic                     o_control_frame,
    output logic                     o_text_message,
    output logic                     o_compressed_message,
    output logic                     o_frame_last,
    output logic                     o_message_last
);
    import wsd_pkg::*;

    // config registers
    logic             r_deflate_en;
    logic [CFG_W-1:0] r_max_body;
    t_cfg             cfg;

    // two-entry result queue, head in slot 0
    t_result    r_q0, n_q0;
    t_result    r_q1, n_q1;
    logic [1:0] r_count, n_count;

    logic    in_acc;
    logic    out_acc;
    t_result step_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deflate_en <= 1'b0;
            r_max_body   <= MAX_BODY_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEFLATE:  r_deflate_en <= i_cfg_data[0];
                CFG_MAX_BODY: r_max_body   <= i_cfg_data;
                default:      r_deflate_en <= r_deflate_en;
            endcase
        end
    end

    assign cfg.deflate_en = r_deflate_en;
    assign cfg.max_body   = r_max_body;

    // stall depends on registered fill level only
    assign o_in_stall  = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    wsd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_byte   (i_data_byte),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_comb begin
        n_q0    = r_q0;
        n_q1    = r_q1;
        n_count = r_count;
        case (r_count)
            2'd0: begin
                if (in_acc) begin
                    n_q0    = step_res;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (in_acc && out_acc) begin
                    n_q0 = step_res;
                end else if (in_acc) begin
                    n_q1    = step_res;
                    n_count = 2'd2;
                end else if (out_acc) begin
                    n_count = 2'd0;
                end
            end
            2'd2: begin
                if (out_acc) begin
                    n_q0    = r_q1;
                    n_count = 2'd1;
                end
            end
            default: n_count = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_status             = r_q0.status;
    assign o_payload_byte       = r_q0.payload_byte;
    assign o_frame_opcode       = r_q0.opcode;
    assign o_control_frame      = r_q0.control;
    assign o_text_message       = r_q0.text;
    assign o_compressed_message = r_q0.compressed;
    assign o_frame_last         = r_q0.frame_last;
    assign o_message_last       = r_q0.message_last;

    `WSD_ASSERT_NOW(a_count_legal, 1'b1, r_count != 2'd3,
        "result queue count out of range")
    `WSD_ASSERT_NEXT(a_count_idle_stable, !in_acc && !out_acc, r_count == $past(r_count),
        "result queue count moved with no request on either side")
    `WSD_ASSERT_NEXT(a_stalled_result_held, o_out_valid && i_out_stall,
        o_out_valid && $stable(r_q0),
        "stalled result changed or dropped")

endmodule
